/* rtl/tpp_pkg.sv */
// Shared types and constants of the turtle pen plotter grid core.
package tpp_pkg;

  localparam int ROW_IDX_W = 5;
  localparam int ROW_BITS_W = 32;
  localparam int MAX_GRID = 32;

  localparam logic [2:0] CMD_PEN_UP    = 3'd0;
  localparam logic [2:0] CMD_PEN_DOWN  = 3'd1;
  localparam logic [2:0] CMD_TURN_RGHT = 3'd2;
  localparam logic [2:0] CMD_TURN_LEFT = 3'd3;
  localparam logic [2:0] CMD_MOVE      = 3'd4;
  localparam logic [2:0] CMD_DUMP      = 3'd5;

  localparam logic [1:0] HEAD_UP    = 2'd0;
  localparam logic [1:0] HEAD_RIGHT = 2'd1;
  localparam logic [1:0] HEAD_DOWN  = 2'd2;
  localparam logic [1:0] HEAD_LEFT  = 2'd3;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] distance;
  } tpp_in_t;

  typedef struct packed {
    logic                  is_row;
    logic [ROW_IDX_W-1:0]  row_index;
    logic [ROW_BITS_W-1:0] row_bits;
    logic [ROW_IDX_W-1:0]  pos_row;
    logic [ROW_IDX_W-1:0]  pos_col;
    logic [1:0]            heading;
    logic                  pen_down;
    logic                  last;
  } tpp_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 apply;
    logic                 step;
    logic                 emit_status;
    logic                 emit_row;
    logic [ROW_IDX_W-1:0] row_idx;
    logic                 row_last;
  } tpp_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic blocked;
  } tpp_sts_t;

endpackage

/* rtl/tpp_ctrl.sv */
// Command sequencer of the turtle pen plotter grid core.
module tpp_ctrl #(
  parameter int GRID_N = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  tpp_pkg::tpp_in_t in_data,
  input  tpp_pkg::tpp_sts_t sts,
  output logic             busy,
  output tpp_pkg::tpp_ctl_t ctl
);
  import tpp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MOVE = 4'b0010,
    S_DUMP = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [7:0]           cnt_r, cnt_nxt;
  logic [ROW_IDX_W-1:0] row_r, row_nxt;
  logic                 row_last;

  assign busy     = (state_r != S_IDLE);
  assign row_last = (row_r == ROW_IDX_W'(GRID_N - 1));

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    row_nxt     = row_r;
    ctl         = '0;
    ctl.row_idx = row_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_data.cmd)
            CMD_MOVE: begin
              cnt_nxt   = in_data.distance;
              state_nxt = S_MOVE;
            end
            CMD_DUMP: begin
              row_nxt   = '0;
              state_nxt = S_DUMP;
            end
            default: begin
              ctl.apply = 1'b1;
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_MOVE: begin
        // The move ends when the distance runs out or the edge is reached.
        if (cnt_r == 8'd0 || sts.blocked) begin
          state_nxt = S_FIN;
        end else begin
          ctl.step = 1'b1;
          cnt_nxt  = cnt_r - 8'd1;
        end
      end
      S_DUMP: begin
        ctl.emit_row = 1'b1;
        ctl.row_last = row_last;
        if (row_last) begin
          state_nxt = S_IDLE;
        end else begin
          row_nxt = row_r + ROW_IDX_W'(1);
        end
      end
      S_FIN: begin
        ctl.emit_status = 1'b1;
        state_nxt       = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      row_r   <= row_nxt;
    end
  end

endmodule

/* rtl/tpp_dpath.sv */
// Turtle state, grid bitmap and result register of the plotter core.
module tpp_dpath #(
  parameter int GRID_N = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tpp_pkg::tpp_in_t  in_data,
  input  tpp_pkg::tpp_ctl_t ctl,
  output tpp_pkg::tpp_sts_t sts,
  output logic              out_valid,
  output tpp_pkg::tpp_out_t out_data
);
  import tpp_pkg::*;

  localparam int POS_W = (GRID_N > 1) ? $clog2(GRID_N) : 1;

  logic [POS_W-1:0]  row_r, row_nxt;
  logic [POS_W-1:0]  col_r, col_nxt;
  logic [1:0]        head_r, head_nxt;
  logic              pen_r, pen_nxt;
  logic [GRID_N-1:0] grid_r [GRID_N];
  logic              out_valid_r;
  tpp_out_t          out_r;

  always_comb begin
    case (head_r)
      HEAD_UP:    sts.blocked = (row_r == '0);
      HEAD_RIGHT: sts.blocked = (col_r == POS_W'(GRID_N - 1));
      HEAD_DOWN:  sts.blocked = (row_r == POS_W'(GRID_N - 1));
      default:    sts.blocked = (col_r == '0);
    endcase
  end

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    head_nxt = head_r;
    pen_nxt  = pen_r;
    if (ctl.apply) begin
      case (in_data.cmd)
        CMD_PEN_UP:    pen_nxt  = 1'b0;
        CMD_PEN_DOWN:  pen_nxt  = 1'b1;
        CMD_TURN_RGHT: head_nxt = head_r + 2'd1;
        CMD_TURN_LEFT: head_nxt = head_r - 2'd1;
        default:       pen_nxt  = pen_r;
      endcase
    end
    // The controller only steps when the edge check is clear.
    if (ctl.step) begin
      case (head_r)
        HEAD_UP:    row_nxt = row_r - POS_W'(1);
        HEAD_RIGHT: col_nxt = col_r + POS_W'(1);
        HEAD_DOWN:  row_nxt = row_r + POS_W'(1);
        default:    col_nxt = col_r - POS_W'(1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      head_r <= HEAD_RIGHT;
      pen_r  <= 1'b0;
      for (int i = 0; i < GRID_N; i++) begin
        grid_r[i] <= '0;
      end
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      head_r <= head_nxt;
      pen_r  <= pen_nxt;
      if (ctl.step && pen_r) begin
        grid_r[row_nxt][col_nxt] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.emit_status || ctl.emit_row;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_status || ctl.emit_row) begin
      out_r.is_row    <= ctl.emit_row;
      out_r.row_index <= ctl.emit_row ? ctl.row_idx : '0;
      out_r.row_bits  <= ctl.emit_row ?
                         ROW_BITS_W'(grid_r[ctl.row_idx[POS_W-1:0]]) : '0;
      out_r.pos_row   <= ROW_IDX_W'(row_r);
      out_r.pos_col   <= ROW_IDX_W'(col_r);
      out_r.heading   <= head_r;
      out_r.pen_down  <= pen_r;
      out_r.last      <= ctl.emit_row ? ctl.row_last : 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/turtle_pen_plotter_grid_core.sv */
// Pen up, pen down, turn and unused commands: the status goes out through the finish state and the output register.
// Move: one cell per cycle; the steps taken (distance clamped at the edge) are
// followed by the status through the finish state and the output register.
// Dump: one row per cycle through the output register, every grid row in order, the last one marked.
// Results cannot be stalled. Synchronous reset clears the grid and the turtle state at once.
module turtle_pen_plotter_grid_core #(
  parameter int GRID_SIZE = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tpp_pkg::tpp_in_t  in_data,
  output logic              out_valid,
  output tpp_pkg::tpp_out_t out_data
);
  import tpp_pkg::*;

  localparam int GRID_N = (GRID_SIZE > MAX_GRID) ? MAX_GRID :
                          ((GRID_SIZE < 1) ? 1 : GRID_SIZE);

  tpp_ctl_t ctl;
  tpp_sts_t sts;

  tpp_ctrl #(
    .GRID_N (GRID_N)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_data (in_data),
    .sts     (sts),
    .busy    (busy),
    .ctl     (ctl)
  );

  tpp_dpath #(
    .GRID_N (GRID_N)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // A status result is always the only result of its transaction.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_row |-> out_data.last)
    else $error("status result without last");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_rows_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_row && !out_data.last |=>
      out_valid && out_data.is_row &&
      out_data.row_index == ROW_IDX_W'($past(out_data.row_index) + ROW_IDX_W'(1)))
    else $error("dump rows not back to back in order");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |=> !out_valid)
    else $error("result directly after a last result");
`endif

endmodule
